>>> design/eeprom_mirror_dirty_range_flush_defines.svh
// Assertion macros shared by the mirror flush design.
`ifndef EEPROM_MIRROR_DIRTY_RANGE_FLUSH_DEFINES_SVH
`define EEPROM_MIRROR_DIRTY_RANGE_FLUSH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EMDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EMDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/emdf_pkg.sv
// Shared types, constants and helpers for the mirror flush design.
package emdf_pkg;

    localparam int MIRROR_BYTES_DEFAULT = 4096;
    localparam int LANES = 4;
    localparam int LANE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] DEFAULT_DELAY_MS = 16'd100;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [15:0] QUIET_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_READY = 2'd1;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_TICK    = 3'd2,
        OP_CLEAN   = 3'd3,
        OP_PRELOAD = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] address;
        logic [1:0]  size_code;
        logic [31:0] data;
        logic        flush_failed;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        flush_valid;
        logic [15:0] flush_start;
        logic [16:0] flush_length;
        logic        reset_request;
        logic        dirty_flag;
    } rsp_t;

    typedef struct packed {
        logic              act;
        logic              wr;
        logic              pre;
        logic [LANE_W-1:0] offs;
        logic [7:0]        wbyte;
    } lane_cmd_t;

    typedef struct packed {
        logic              changed;
        logic [LANE_W-1:0] offs;
        logic [7:0]        rbyte;
    } lane_res_t;

    function automatic logic [2:0] access_bytes(input logic [1:0] size_code);
        logic [2:0] n;
        case (size_code)
            2'd0:    n = 3'd1;
            2'd1:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

>>> design/emdf_lane.sv
// One byte lane: a bank of the mirror with read, compare and write.
module emdf_lane #(
    parameter int ROWS = emdf_pkg::MIRROR_BYTES_DEFAULT / emdf_pkg::LANES,
    parameter int ROW_W = $clog2(ROWS)
) (
    input  logic                 clk,
    input  logic                 clr_en,
    input  logic [ROW_W-1:0]     clr_row,
    input  logic                 rd_en,
    input  logic [ROW_W-1:0]     rd_row,
    input  logic                 fire,
    input  emdf_pkg::lane_cmd_t  cmd,
    input  logic [ROW_W-1:0]     wr_row,
    output emdf_pkg::lane_res_t  res
);

    logic [7:0]       mirror_reg [ROWS];
    logic [7:0]       rd_byte_reg;
    logic             changed;
    logic             we;
    logic [ROW_W-1:0] wrow;
    logic [7:0]       wdata;

    always_comb
    begin
        changed = cmd.act && cmd.wr && (rd_byte_reg != cmd.wbyte);
        we      = clr_en || (fire && cmd.act && (cmd.wr ? changed : cmd.pre));
        wrow    = clr_en ? clr_row : wr_row;
        wdata   = clr_en ? emdf_pkg::ERASED_BYTE : cmd.wbyte;
        res.changed = changed;
        res.offs    = cmd.offs;
        res.rbyte   = cmd.act ? rd_byte_reg : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mirror_reg[wrow] <= wdata;
        end
        if (rd_en)
        begin
            rd_byte_reg <= mirror_reg[rd_row];
        end
    end

endmodule

>>> design/emdf_merge.sv
// Merge of lane findings: dirty range, quiet counter, flush and result.
`include "eeprom_mirror_dirty_range_flush_defines.svh"

module emdf_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [2:0]          op,
    input  logic [15:0]         address,
    input  logic                flush_failed,
    input  logic [15:0]         flush_delay,
    input  logic                backend_ready,
    input  emdf_pkg::lane_res_t lane_res [emdf_pkg::LANES],
    output emdf_pkg::rsp_t      result
);

    logic        dirty_reg, dirty_next;
    logic [15:0] dirty_low_reg, dirty_low_next;
    logic [15:0] dirty_high_reg, dirty_high_next;
    logic [15:0] quiet_reg, quiet_next;
    logic        clean_pending_reg, clean_pending_next;

    logic                        any_changed;
    logic [emdf_pkg::LANE_W-1:0] min_off;
    logic [emdf_pkg::LANE_W-1:0] max_off;
    logic [15:0]                 cmin;
    logic [15:0]                 cmax;
    logic [15:0]                 quiet_inc;
    logic                        do_flush;
    logic [31:0]                 rdata;

    always_comb
    begin
        any_changed = 1'b0;
        min_off     = '1;
        max_off     = '0;
        rdata       = 32'd0;
        for (int b = 0; b < emdf_pkg::LANES; b++)
        begin
            rdata = rdata | (32'(lane_res[b].rbyte) << (8 * lane_res[b].offs));
            if (lane_res[b].changed)
            begin
                any_changed = 1'b1;
                if (lane_res[b].offs < min_off)
                begin
                    min_off = lane_res[b].offs;
                end
                if (lane_res[b].offs > max_off)
                begin
                    max_off = lane_res[b].offs;
                end
            end
        end
        cmin = address + 16'(min_off);
        cmax = address + 16'(max_off);
        quiet_inc = (quiet_reg == emdf_pkg::QUIET_MAX) ? quiet_reg : quiet_reg + 16'd1;

        dirty_next         = dirty_reg;
        dirty_low_next     = dirty_low_reg;
        dirty_high_next    = dirty_high_reg;
        quiet_next         = quiet_reg;
        clean_pending_next = clean_pending_reg;
        do_flush           = 1'b0;

        result = '0;

        unique case (op)
            emdf_pkg::OP_READ:
            begin
                result.read_data = rdata;
            end
            emdf_pkg::OP_WRITE:
            begin
                if (any_changed)
                begin
                    quiet_next = 16'd0;
                    dirty_next = 1'b1;
                    if (!dirty_reg)
                    begin
                        dirty_low_next  = cmin;
                        dirty_high_next = cmax;
                    end
                    else
                    begin
                        dirty_low_next  = (cmin < dirty_low_reg) ? cmin : dirty_low_reg;
                        dirty_high_next = (cmax > dirty_high_reg) ? cmax : dirty_high_reg;
                    end
                end
            end
            emdf_pkg::OP_TICK:
            begin
                quiet_next = quiet_inc;
                do_flush = dirty_reg && (quiet_inc >= flush_delay);
                result.reset_request = clean_pending_reg;
            end
            emdf_pkg::OP_CLEAN:
            begin
                do_flush = dirty_reg;
                clean_pending_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_flush)
        begin
            if (backend_ready)
            begin
                result.flush_valid  = 1'b1;
                result.flush_start  = dirty_low_reg;
                result.flush_length = {1'b0, dirty_high_reg} - {1'b0, dirty_low_reg}
                                      + 17'd1;
                dirty_next = flush_failed;
            end
            else
            begin
                dirty_next = 1'b0;
            end
        end

        result.dirty_flag = dirty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg         <= 1'b0;
            dirty_low_reg     <= 16'd0;
            dirty_high_reg    <= 16'd0;
            quiet_reg         <= 16'd0;
            clean_pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            dirty_reg         <= dirty_next;
            dirty_low_reg     <= dirty_low_next;
            dirty_high_reg    <= dirty_high_next;
            quiet_reg         <= quiet_next;
            clean_pending_reg <= clean_pending_next;
        end
    end

    `EMDF_ASSERT_IMP(a_flush_needs_dirty, clk, rst_n, fire && result.flush_valid, dirty_reg)
    `EMDF_ASSERT_IMP(a_range_ordered, clk, rst_n, dirty_reg, dirty_low_reg <= dirty_high_reg)
    `EMDF_ASSERT_IMP(a_flush_length_nonzero, clk, rst_n, fire && result.flush_valid,
                     result.flush_length != 17'd0)

endmodule

>>> design/eeprom_mirror_dirty_range_flush.sv
// Top level of the EEPROM byte mirror with coalesced dirty-range flushing.
//
// Request channel (req_valid, req_stall, req) carries reads, writes,
// millisecond ticks, clean requests and preload bytes. Response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one transaction per request.
// Configuration is written through cfg_write_en, cfg_index and cfg_data.
//
// The mirror is split into four byte lanes, one bank each, so a 1, 2 or
// 4 byte access touches each bank at most once. A request is read from the
// banks at the accept edge; at the fire edge, once the response register is
// free, it is compared, written, merged into the dirty range and loaded into
// the response register. req_stall stays high while a request waits in the
// second stage, so a new request is accepted only after the last one fires.
//
// After reset the banks are filled with 0xFF, one row per cycle;
// req_stall stays high meanwhile. Configuration writes are taken at any time.
// While rsp_stall holds a response, one more request is accepted and held
// in the second stage until the response register frees.
`include "eeprom_mirror_dirty_range_flush_defines.svh"

module eeprom_mirror_dirty_range_flush #(
    parameter int MIRROR_BYTES = emdf_pkg::MIRROR_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  emdf_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output emdf_pkg::rsp_t                    rsp,
    input  logic                              cfg_write_en,
    input  logic [emdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [emdf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ROWS = (MIRROR_BYTES + emdf_pkg::LANES - 1) / emdf_pkg::LANES;
    localparam int ROW_W = $clog2(ROWS);

    logic             clearing_reg, clearing_next;
    logic [ROW_W-1:0] clear_row_reg, clear_row_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [15:0]      flush_delay_reg;
    logic             backend_ready_reg;

    logic [2:0]       op_reg;
    logic [15:0]      addr_reg;
    logic             failed_reg;
    emdf_pkg::rsp_t   rsp_reg;

    emdf_pkg::lane_cmd_t lane_cmd_next [emdf_pkg::LANES];
    emdf_pkg::lane_cmd_t lane_cmd_reg  [emdf_pkg::LANES];
    logic [ROW_W-1:0]    lane_row_next [emdf_pkg::LANES];
    logic [ROW_W-1:0]    lane_row_reg  [emdf_pkg::LANES];
    emdf_pkg::lane_res_t lane_res      [emdf_pkg::LANES];
    emdf_pkg::rsp_t      merge_result;

    logic accept;
    logic fire;

    assign req_stall = clearing_reg || s1_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign fire      = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [emdf_pkg::LANE_W-1:0] offs;
        logic [2:0]                  n;
        logic                        in_acc;
        logic                        mem_op;
        logic [16:0]                 pos;
        n = emdf_pkg::access_bytes(req.size_code);
        mem_op = (req.op == emdf_pkg::OP_READ) || (req.op == emdf_pkg::OP_WRITE)
                 || (req.op == emdf_pkg::OP_PRELOAD);
        for (int b = 0; b < emdf_pkg::LANES; b++)
        begin
            offs = emdf_pkg::LANE_W'(b) - req.address[emdf_pkg::LANE_W-1:0];
            if (req.op == emdf_pkg::OP_PRELOAD)
            begin
                in_acc = (offs == '0);
            end
            else
            begin
                in_acc = ({1'b0, offs} < n);
            end
            pos = {1'b0, req.address} + 17'(offs);
            lane_cmd_next[b].act   = mem_op && in_acc && (pos < 17'(MIRROR_BYTES));
            lane_cmd_next[b].wr    = (req.op == emdf_pkg::OP_WRITE);
            lane_cmd_next[b].pre   = (req.op == emdf_pkg::OP_PRELOAD);
            lane_cmd_next[b].offs  = offs;
            lane_cmd_next[b].wbyte = req.data[8*offs +: 8];
            lane_row_next[b]       = pos[ROW_W+1:2];
        end
    end

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_row_next = clear_row_reg;
        if (clearing_reg)
        begin
            if (clear_row_reg == ROW_W'(ROWS - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clear_row_next = clear_row_reg + 1'b1;
            end
        end
        s1_valid_next = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg      <= 1'b1;
            clear_row_reg     <= '0;
            s1_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            flush_delay_reg   <= emdf_pkg::DEFAULT_DELAY_MS;
            backend_ready_reg <= 1'b1;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_row_reg <= clear_row_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    emdf_pkg::CFG_FLUSH_DELAY:   flush_delay_reg   <= cfg_data;
                    emdf_pkg::CFG_BACKEND_READY: backend_ready_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.op;
            addr_reg   <= req.address;
            failed_reg <= req.flush_failed;
            for (int b = 0; b < emdf_pkg::LANES; b++)
            begin
                lane_cmd_reg[b] <= lane_cmd_next[b];
                lane_row_reg[b] <= lane_row_next[b];
            end
        end
        if (fire)
        begin
            rsp_reg <= merge_result;
        end
    end

    for (genvar g = 0; g < emdf_pkg::LANES; g++)
    begin : g_lane
        emdf_lane #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_lane (
            .clk     (clk),
            .clr_en  (clearing_reg),
            .clr_row (clear_row_reg),
            .rd_en   (accept),
            .rd_row  (lane_row_next[g]),
            .fire    (fire),
            .cmd     (lane_cmd_reg[g]),
            .wr_row  (lane_row_reg[g]),
            .res     (lane_res[g])
        );
    end

    emdf_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .op            (op_reg),
        .address       (addr_reg),
        .flush_failed  (failed_reg),
        .flush_delay   (flush_delay_reg),
        .backend_ready (backend_ready_reg),
        .lane_res      (lane_res),
        .result        (merge_result)
    );

    `EMDF_ASSERT_NXT(a_accept_loads_stage, clk, rst_n, accept, s1_valid_reg)
    `EMDF_ASSERT_NXT(a_stage_holds_on_stall, clk, rst_n,
                     s1_valid_reg && rsp_valid && rsp_stall, s1_valid_reg && rsp_valid)
    `EMDF_ASSERT_IMP(a_no_work_while_clearing, clk, rst_n, s1_valid_reg, !clearing_reg)

endmodule

>>> sim/eeprom_mirror_dirty_range_flush_tb.sv
// Self-checking testbench for the EEPROM mirror with coalesced dirty-range flushing.
`timescale 1ns / 1ps

module eeprom_mirror_dirty_range_flush_tb;

    localparam int MIRROR_BYTES = emdf_pkg::MIRROR_BYTES_DEFAULT;
    localparam int CFG_W = emdf_pkg::CFG_DATA_W;
    localparam int IDX_W = emdf_pkg::CFG_IDX_W;
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_MID = 3'd6;
    localparam logic [2:0] OP_RESERVED_LAST = 3'd7;
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_WIDE = 2'd3;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 70;

    class mirror_scoreboard;
        logic [7:0] image [0:MIRROR_BYTES-1];
        bit dirty;
        int unsigned dirty_low;
        int unsigned dirty_high;
        int unsigned quiet_ms;
        bit clean_pending;
        logic [15:0] delay_ms;
        bit backend_ready;
        emdf_pkg::rsp_t expected_q[$];
        int unsigned responses_checked;
        int unsigned flushes_seen;

        function new();
            foreach (image[i]) image[i] = emdf_pkg::ERASED_BYTE;
            dirty = 1'b0;
            dirty_low = 0;
            dirty_high = 0;
            quiet_ms = 0;
            clean_pending = 1'b0;
            delay_ms = emdf_pkg::DEFAULT_DELAY_MS;
            backend_ready = 1'b1;
            responses_checked = 0;
            flushes_seen = 0;
        endfunction

        function void configure(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == emdf_pkg::CFG_FLUSH_DELAY)
                delay_ms = value;
            else if (index == emdf_pkg::CFG_BACKEND_READY)
                backend_ready = value[0];
        endfunction

        function void flush_range(bit failed, inout emdf_pkg::rsp_t result);
            if (!dirty)
                return;
            if (backend_ready)
            begin
                result.flush_valid = 1'b1;
                result.flush_start = dirty_low[15:0];
                result.flush_length = 17'(dirty_high - dirty_low + 1);
                if (failed)
                    return;
            end
            dirty = 1'b0;
        endfunction

        function void note_request(emdf_pkg::req_t item);
            emdf_pkg::rsp_t result;
            int unsigned nbytes;
            int unsigned pos;
            logic [7:0] value;
            result = '0;
            if (item.size_code == SIZE_BYTE)
                nbytes = 1;
            else if (item.size_code == SIZE_HALF)
                nbytes = 2;
            else
                nbytes = 4;
            case (item.op)
                emdf_pkg::OP_READ:
                begin
                    for (int i = 0; i < nbytes; i++)
                    begin
                        pos = int'(item.address) + i;
                        if (pos < MIRROR_BYTES)
                            result.read_data[8*i +: 8] = image[pos];
                    end
                end
                emdf_pkg::OP_WRITE:
                begin
                    for (int i = 0; i < nbytes; i++)
                    begin
                        pos = int'(item.address) + i;
                        value = item.data[8*i +: 8];
                        if (pos < MIRROR_BYTES && image[pos] != value)
                        begin
                            image[pos] = value;
                            if (!dirty)
                            begin
                                dirty_low = pos;
                                dirty_high = pos;
                                dirty = 1'b1;
                            end
                            else
                            begin
                                if (pos < dirty_low)
                                    dirty_low = pos;
                                if (pos > dirty_high)
                                    dirty_high = pos;
                            end
                            quiet_ms = 0;
                        end
                    end
                end
                emdf_pkg::OP_TICK:
                begin
                    if (quiet_ms < emdf_pkg::QUIET_MAX)
                        quiet_ms++;
                    if (dirty && quiet_ms >= delay_ms)
                        flush_range(item.flush_failed, result);
                    if (clean_pending)
                        result.reset_request = 1'b1;
                end
                emdf_pkg::OP_CLEAN:
                begin
                    flush_range(item.flush_failed, result);
                    clean_pending = 1'b1;
                end
                emdf_pkg::OP_PRELOAD:
                begin
                    if (item.address < MIRROR_BYTES)
                        image[item.address] = item.data[7:0];
                end
                default: ;
            endcase
            result.dirty_flag = dirty;
            expected_q.push_back(result);
        endfunction

        function string check_response(emdf_pkg::rsp_t got);
            emdf_pkg::rsp_t want;
            string diffs;
            diffs = "";
            if (expected_q.size() == 0)
                return $sformatf("response %h arrived with no request outstanding", got);
            want = expected_q.pop_front();
            responses_checked++;
            if (want.flush_valid)
                flushes_seen++;
            if (got.read_data !== want.read_data)
                diffs = {diffs, $sformatf(" read_data %h/%h", got.read_data, want.read_data)};
            if (got.flush_valid !== want.flush_valid)
                diffs = {diffs, $sformatf(" flush_valid %b/%b",
                                          got.flush_valid, want.flush_valid)};
            if (got.flush_start !== want.flush_start)
                diffs = {diffs, $sformatf(" flush_start %h/%h",
                                          got.flush_start, want.flush_start)};
            if (got.flush_length !== want.flush_length)
                diffs = {diffs, $sformatf(" flush_length %h/%h",
                                          got.flush_length, want.flush_length)};
            if (got.reset_request !== want.reset_request)
                diffs = {diffs, $sformatf(" reset_request %b/%b",
                                          got.reset_request, want.reset_request)};
            if (got.dirty_flag !== want.dirty_flag)
                diffs = {diffs, $sformatf(" dirty_flag %b/%b",
                                          got.dirty_flag, want.dirty_flag)};
            if (diffs != "")
                return $sformatf("response %0d (got/expected):%s", responses_checked, diffs);
            return "";
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    emdf_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    emdf_pkg::rsp_t rsp;
    logic cfg_write_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    mirror_scoreboard sb;
    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned op_count [0:7];
    int unsigned burst_left = 0;
    int unsigned settings_used = 1;
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;
    logic [15:0] stall_clock = '0;
    int stall_mode = 0;

    eeprom_mirror_dirty_range_flush #(
        .MIRROR_BYTES(MIRROR_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR: %s", what);
    endtask

    task automatic send_item(input logic [2:0] op, input logic [15:0] address,
                             input logic [1:0] size_code, input logic [31:0] data,
                             input logic failed);
        emdf_pkg::req_t item;
        item.op = op;
        item.address = address;
        item.size_code = size_code;
        item.data = data;
        item.flush_failed = failed;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (idle_on && $urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.configure(index, value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Track accepted transactions on both channels.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            sb.note_request(req);
            op_count[req.op]++;
        end
    end

    always @(posedge clk)
    begin : watch_rsp
        string what;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            what = sb.check_response(rsp);
            if (what != "")
                report_mismatch(what);
        end
    end

    // Receiver stall pattern: switch modes whenever the low six bits of stall_clock are zero.
    always @(posedge clk)
    begin
        stall_clock <= stall_clock + 16'd1;
        if (stall_clock[5:0] == 6'd0)
            stall_mode <= $urandom_range(0, 3);
        if (!stall_on)
            rsp_stall <= 1'b0;
        else
        begin
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= (stall_clock[1:0] == 2'd3);
                2: rsp_stall <= 1'($urandom_range(0, 1));
                default: rsp_stall <= (stall_clock[3:0] < 4'd8);
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d responses still outstanding", sb.pending());
        $display("eeprom_mirror_dirty_range_flush_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] delays [0:PHASES-1];
        bit readies [0:PHASES-1];
        int unsigned pick;
        logic [2:0] op;
        logic [15:0] address;
        logic [31:0] data;

        delays = '{16'd0, 16'd3, 16'd65535, 16'd1, 16'd8, 16'd2};
        readies = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        foreach (op_count[i]) op_count[i] = 0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration.
        send_item(emdf_pkg::OP_READ, 16'd0, SIZE_WORD, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_WRITE, 16'd0, SIZE_WORD, 32'h1234_5678, 1'b0);
        send_item(emdf_pkg::OP_READ, 16'd0, SIZE_WORD, 32'hFFFF_FFFF, 1'b1);
        send_item(emdf_pkg::OP_WRITE, 16'd4095, SIZE_BYTE, 32'hFFFF_FF00, 1'b0);
        send_item(emdf_pkg::OP_WRITE, 16'd4094, SIZE_WIDE, 32'hA5A5_5A5A, 1'b0);
        send_item(emdf_pkg::OP_READ, 16'd4094, SIZE_WORD, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_WRITE, 16'hFFFF, SIZE_WORD, 32'h0, 1'b1);
        send_item(emdf_pkg::OP_READ, 16'hFFFF, SIZE_WIDE, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_WRITE, 16'd1, SIZE_HALF, 32'h0000_3456, 1'b0);
        send_item(emdf_pkg::OP_TICK, 16'd0, SIZE_BYTE, 32'h0, 1'b1);
        send_item(emdf_pkg::OP_CLEAN, 16'h8000, SIZE_WIDE, 32'hFFFF_FFFF, 1'b1);
        send_item(emdf_pkg::OP_CLEAN, 16'd0, SIZE_BYTE, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_CLEAN, 16'd0, SIZE_BYTE, 32'h0, 1'b1);
        send_item(emdf_pkg::OP_TICK, 16'hFFFF, SIZE_WIDE, 32'hFFFF_FFFF, 1'b0);
        send_item(emdf_pkg::OP_PRELOAD, 16'd10, SIZE_BYTE, 32'hABCD_EF77, 1'b0);
        send_item(emdf_pkg::OP_PRELOAD, 16'd5000, SIZE_WIDE, 32'h0000_0011, 1'b0);
        send_item(emdf_pkg::OP_PRELOAD, 16'd4095, SIZE_BYTE, 32'h0000_00C3, 1'b0);
        send_item(emdf_pkg::OP_READ, 16'd9, SIZE_HALF, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_READ, 16'd4095, SIZE_HALF, 32'h0, 1'b0);
        send_item(OP_RESERVED_FIRST, 16'h1234, SIZE_HALF, 32'hDEAD_BEEF, 1'b1);
        send_item(OP_RESERVED_MID, 16'd4, SIZE_BYTE, 32'h0, 1'b0);
        send_item(OP_RESERVED_LAST, 16'hFFFF, SIZE_WIDE, 32'hFFFF_FFFF, 1'b1);
        send_item(emdf_pkg::OP_TICK, 16'd0, SIZE_BYTE, 32'h0, 1'b0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_reg(emdf_pkg::CFG_FLUSH_DELAY, delays[phase]);
            write_reg(emdf_pkg::CFG_BACKEND_READY, CFG_W'(readies[phase]));
            settings_used++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    op = emdf_pkg::OP_READ;
                else if (pick < 55)
                    op = emdf_pkg::OP_WRITE;
                else if (pick < 83)
                    op = emdf_pkg::OP_TICK;
                else if (pick < 86)
                    op = emdf_pkg::OP_CLEAN;
                else if (pick < 95)
                    op = emdf_pkg::OP_PRELOAD;
                else
                    op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: address = 16'($urandom_range(0, 47));
                    6: address = 16'($urandom_range(4088, 4095));
                    7: address = 16'($urandom_range(4096, 4103));
                    8: address = 16'($urandom_range(0, 65535));
                    default: address = 16'($urandom_range(65532, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0: data = $urandom;
                    1: data = 32'h0;
                    2: data = 32'hFFFF_FFFF;
                    default: data = {4{8'($urandom_range(0, 3))}};
                endcase
                send_item(op, address, 2'($urandom_range(0, 3)), data,
                          $urandom_range(0, 2) == 0);
            end
            wait_drained();
        end

        // Fail one flush, then let the next tick retry it.
        write_reg(emdf_pkg::CFG_FLUSH_DELAY, 16'd2);
        write_reg(emdf_pkg::CFG_BACKEND_READY, CFG_W'(1));
        settings_used++;
        idle_on = 1'b0;
        stall_on = 1'b0;
        send_item(emdf_pkg::OP_WRITE, 16'd100, SIZE_BYTE, 32'h11, 1'b0);
        send_item(emdf_pkg::OP_WRITE, 16'd100, SIZE_BYTE, 32'h22, 1'b0);
        send_item(emdf_pkg::OP_TICK, 16'd0, SIZE_BYTE, 32'h0, 1'b1);
        send_item(emdf_pkg::OP_TICK, 16'd0, SIZE_BYTE, 32'h0, 1'b1);
        send_item(emdf_pkg::OP_TICK, 16'd0, SIZE_BYTE, 32'h0, 1'b0);
        send_item(emdf_pkg::OP_READ, 16'd100, SIZE_BYTE, 32'h0, 1'b0);

        wait_drained();
        repeat (6) @(posedge clk);
        $display("run covered %0d transactions over %0d settings: %0d reads, %0d writes,",
                 requests_sent, settings_used, op_count[emdf_pkg::OP_READ],
                 op_count[emdf_pkg::OP_WRITE]);
        $display("%0d ticks, %0d cleans, %0d preloads; %0d responses checked, %0d flushes",
                 op_count[emdf_pkg::OP_TICK], op_count[emdf_pkg::OP_CLEAN],
                 op_count[emdf_pkg::OP_PRELOAD], sb.responses_checked, sb.flushes_seen);
        if (mismatches == 0)
            $display("eeprom_mirror_dirty_range_flush_tb passed");
        else
            $display("eeprom_mirror_dirty_range_flush_tb failed");
        $finish;
    end

endmodule
